FILE: src/mib_pkg.sv
// shared types and constants for the binary modular inverse block
// no dependencies
package mib_pkg;

  localparam int DEFAULT_WIDTH = 32;
  localparam int CFG_W         = 32;
  localparam int OPERAND_W     = 32;
  localparam int INVERSE_W     = 32;
  localparam int HCOUNT_W      = 8;

  localparam logic [CFG_W-1:0] MODULUS_RESET = 32'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic p1_step;
    logic reduce;
    logic negate;
    logic p2_step;
  } mib_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic v_zero;
    logic bad_operand;
  } mib_sts_t;

endpackage

FILE: src/mib_dpath.sv
// datapath of the binary modular inverse: modulus register, u/v/r/s registers
// and the load, phase one, reduce, negate and phase two logic; uses mib_pkg
module mib_dpath import mib_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [OPERAND_W-1:0] in_operand,
  input  mib_cmd_t             cmd,
  output mib_sts_t             sts,
  output logic [WIDTH-1:0]     result
);

  logic [CFG_W-1:0] modulus_r;
  logic [WIDTH-1:0] u_r, v_r;
  logic [WIDTH:0]   r_r, s_r;

  logic [WIDTH-1:0] p_w, a_w;
  logic [WIDTH:0]   p_x;
  logic [WIDTH-1:0] u_nxt, v_nxt;
  logic [WIDTH:0]   r_nxt, s_nxt;
  logic [WIDTH-1:0] u_minus_v, v_minus_u;
  logic [WIDTH:0]   r_plus_s, r_plus_p;

  assign p_w = WIDTH'(modulus_r);
  assign a_w = WIDTH'(in_operand);
  assign p_x = {1'b0, p_w};

  assign sts.bad_operand = (a_w == '0) || (a_w > p_w);
  assign sts.v_zero      = (v_r == '0);

  assign u_minus_v = u_r - v_r;
  assign v_minus_u = v_r - u_r;
  assign r_plus_s  = r_r + s_r;
  assign r_plus_p  = r_r + p_x;

  always_comb begin
    u_nxt = u_r;
    v_nxt = v_r;
    r_nxt = r_r;
    s_nxt = s_r;
    if (cmd.load) begin
      u_nxt = p_w;
      v_nxt = a_w;
      r_nxt = '0;
      s_nxt = (WIDTH+1)'(1);
    end else if (cmd.p1_step) begin
      priority if (!u_r[0]) begin
        u_nxt = u_r >> 1;
        s_nxt = s_r << 1;
      end else if (!v_r[0]) begin
        v_nxt = v_r >> 1;
        r_nxt = r_r << 1;
      end else if (u_r > v_r) begin
        u_nxt = u_minus_v >> 1;
        r_nxt = r_plus_s;
        s_nxt = s_r << 1;
      end else begin
        v_nxt = v_minus_u >> 1;
        s_nxt = r_plus_s;
        r_nxt = r_r << 1;
      end
    end else if (cmd.reduce) begin
      if (r_r >= p_x) begin
        r_nxt = r_r - p_x;
      end
    end else if (cmd.negate) begin
      r_nxt = p_x - r_r;
    end else if (cmd.p2_step) begin
      // halve modulo p: odd values get p added first
      if (r_r[0]) begin
        r_nxt = r_plus_p >> 1;
      end else begin
        r_nxt = r_r >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      modulus_r <= MODULUS_RESET;
    end else if (cfg_we) begin
      modulus_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    u_r <= u_nxt;
    v_r <= v_nxt;
    r_r <= r_nxt;
    s_r <= s_nxt;
  end

  assign result = r_r[WIDTH-1:0];

endmodule

FILE: src/mib_ctrl.sv
// controller of the binary modular inverse: sequencing state machine,
// halving counters and result strobe; uses mib_pkg
module mib_ctrl import mib_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  mib_sts_t            sts,
  output mib_cmd_t            cmd,
  output logic                busy,
  output logic                out_valid,
  output logic                out_status,
  output logic [HCOUNT_W-1:0] out_halving_count
);

  localparam int KW = $clog2(2*WIDTH + 1);
  localparam logic [KW-1:0] K_MAX = KW'(2*WIDTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_P1,
    S_RED,
    S_NEG,
    S_P2
  } state_t;

  state_t        state_r;
  logic [KW-1:0] k_r, j_r;
  logic          valid_r, err_r;

  logic accept;
  logic p1_done, p2_done;

  assign accept  = start && (state_r == S_IDLE);
  assign p1_done = sts.v_zero || (k_r == K_MAX);
  assign p2_done = (j_r == k_r);

  assign cmd.load    = accept && !sts.bad_operand;
  assign cmd.p1_step = (state_r == S_P1) && !p1_done;
  assign cmd.reduce  = (state_r == S_RED);
  assign cmd.negate  = (state_r == S_NEG);
  assign cmd.p2_step = (state_r == S_P2) && !p2_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      j_r     <= '0;
      valid_r <= 1'b0;
      err_r   <= 1'b0;
    end else begin
      valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (sts.bad_operand) begin
              // range error: answer at once, no iterations
              valid_r <= 1'b1;
              err_r   <= 1'b1;
            end else begin
              k_r     <= '0;
              j_r     <= '0;
              state_r <= S_P1;
            end
          end
        end
        S_P1: begin
          if (p1_done) begin
            state_r <= S_RED;
          end else begin
            k_r <= k_r + KW'(1);
          end
        end
        S_RED: begin
          state_r <= S_NEG;
        end
        S_NEG: begin
          state_r <= S_P2;
        end
        S_P2: begin
          if (p2_done) begin
            valid_r <= 1'b1;
            err_r   <= 1'b0;
            state_r <= S_IDLE;
          end else begin
            j_r <= j_r + KW'(1);
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = valid_r;
  assign out_status        = err_r;
  assign out_halving_count = err_r ? '0 : HCOUNT_W'({k_r, 1'b0});

`ifndef SYNTHESIS
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start");

  a_k_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P1) |-> (k_r <= K_MAX))
    else $error("phase one step count beyond its cap");

  a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_P2) |-> (j_r <= k_r))
    else $error("phase two count passed phase one count");

  a_ok_after_p2: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !err_r) |-> ($past(state_r) == S_P2))
    else $error("good result not preceded by phase two");
`endif

endmodule

FILE: src/modular_inverse_binary.sv
// top level of the binary modular inverse (almost Montgomery inverse method)
// instantiates mib_ctrl and mib_dpath; uses mib_pkg
//
// An item is taken when start is high and busy is low; it computes
// operand^-1 mod modulus in two phases over a shared step datapath, one step
// per clock: phase one runs k steps and then exits, then the remainder is
// reduced and negated, then phase two runs k halving steps and exits; busy stays
// high throughout (k is at most 2*WIDTH, typically between the bit length of
// the modulus and twice that). The result shows for exactly one cycle with
// out_valid and cannot be held off; a new start is taken in that same cycle.
// An operand of zero or above the modulus never raises busy and gives
// out_status = 1 with zero fields in the cycle after start.
module modular_inverse_binary import mib_pkg::*; #(
  parameter int WIDTH = DEFAULT_WIDTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic                 start,
  output logic                 busy,
  input  logic [OPERAND_W-1:0] in_operand,
  output logic                 out_valid,
  output logic [INVERSE_W-1:0] out_inverse,
  output logic [HCOUNT_W-1:0]  out_halving_count,
  output logic                 out_status
);

  mib_cmd_t         cmd;
  mib_sts_t         sts;
  logic [WIDTH-1:0] result;

  mib_ctrl #(
    .WIDTH (WIDTH)
  ) u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .sts               (sts),
    .cmd               (cmd),
    .busy              (busy),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_halving_count (out_halving_count)
  );

  mib_dpath #(
    .WIDTH (WIDTH)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_operand (in_operand),
    .cmd        (cmd),
    .sts        (sts),
    .result     (result)
  );

  assign out_inverse = out_status ? '0 : INVERSE_W'(result);

endmodule
